// File: hw/rtl/bge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bigram entropy package
// Types, constants and state codes shared by the bigram entropy unit.
// ----------------------------------------------------------------------------
package bge_pkg;

    localparam int COUNT_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 20;

    localparam int NSYM      = 34;
    localparam int NPAIR     = NSYM * NSYM;
    localparam int SYM_W     = 6;
    localparam int UNI_AW    = 6;
    localparam int PAIR_AW   = 11;
    localparam int FIELD_W   = 24;
    localparam int LG_INT_W  = 5;
    localparam int QDEPTH    = 4;
    localparam int PADDR_W   = 2;

    localparam logic [SYM_W-1:0]   SPACE_SYM = 6'd33;
    localparam logic [FIELD_W-1:0] FIELD_MAX = 24'hFFFFFF;

    localparam logic [1:0] TBL_UNI = 2'd0;
    localparam logic [1:0] TBL_OVL = 2'd1;
    localparam logic [1:0] TBL_ALN = 2'd2;

    localparam logic [PADDR_W-1:0] REG_KEEP_SPACES = 2'd0;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0] unigram_entropy;
        logic [FIELD_W-1:0] overlap_bigram_entropy;
        logic [FIELD_W-1:0] paired_bigram_entropy;
        logic [FIELD_W-1:0] symbol_count;
        logic               too_short;
        logic               count_overflow;
    } out_beat_t;

    typedef struct packed {
        logic             sym_valid;
        logic [SYM_W-1:0] sym;
        logic             add_space;
        logic             finish;
    } q_entry_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_DISPATCH, ST_ADD_RD, ST_ADD_WR, ST_LT_START, ST_LT_WAIT,
        ST_RD, ST_DATA, ST_LC_WAIT, ST_MUL, ST_ACC, ST_NEXT, ST_DIV_START, ST_DIV,
        ST_STORE, ST_RESULT
    } back_state_t;

    typedef enum logic [1:0] {
        LG_IDLE, LG_NORM, LG_SQR, LG_DONE
    } lg_state_t;

endpackage

// File: hw/rtl/bge_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bge_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 34
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// File: hw/rtl/bge_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bigram entropy front end
// Folds case, classifies each byte and queues symbol, separator and finish work.
// ----------------------------------------------------------------------------
module bge_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bge_pkg::in_beat_t     s_data,
    input  logic                  keep_spaces,
    input  bge_pkg::back_status_t status,
    input  logic                  q_full,
    output logic                  q_push,
    output bge_pkg::q_entry_t     q_data
);

    logic       inside_word_reg;
    logic       inside_word_next;
    logic [7:0] folded;
    logic [7:0] offset;
    logic       letter;
    logic       accept;

    assign s_ready = !q_full && !status.clearing;
    assign accept  = s_valid && s_ready;

    always_comb begin
        folded = s_data.text_byte;
        if (s_data.text_byte >= 8'hC0 && s_data.text_byte <= 8'hDF) begin
            folded = s_data.text_byte + 8'h20;
        end
        letter = (folded >= 8'hE0) || (folded == 8'hB8);
        offset = folded - 8'hE0;
        q_data.sym_valid = letter;
        if (folded == 8'hB8) begin
            q_data.sym = 6'd6;
        end else if (offset <= 8'd5) begin
            q_data.sym = offset[bge_pkg::SYM_W-1:0];
        end else begin
            q_data.sym = 6'(offset + 8'd1);
        end
        if (letter) begin
            q_data.add_space = s_data.end_of_text && keep_spaces;
        end else begin
            q_data.add_space = inside_word_reg && keep_spaces;
        end
        q_data.finish    = s_data.end_of_text;
        inside_word_next = letter && !s_data.end_of_text;
    end

    assign q_push = accept && (q_data.sym_valid || q_data.add_space || q_data.finish);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_word_reg <= 1'b0;
        end else if (accept) begin
            inside_word_reg <= inside_word_next;
        end
    end

endmodule

// File: hw/rtl/bge_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bigram entropy work queue
// A short queue of classified work between the front end and the back end.
// ----------------------------------------------------------------------------
module bge_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bge_pkg::q_entry_t din,
    input  logic              pop,
    output bge_pkg::q_entry_t dout,
    output logic              full,
    output logic              empty
);

    localparam int PW = $clog2(bge_pkg::QDEPTH);

    bge_pkg::q_entry_t mem_reg [bge_pkg::QDEPTH];
    logic [PW-1:0]     wptr_reg;
    logic [PW-1:0]     rptr_reg;
    logic [PW:0]       count_reg;

    assign full  = count_reg == (PW+1)'(bge_pkg::QDEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/bge_lg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point base-2 logarithm
// Finds the leading one bit by bit, then one fraction bit per squaring.
// ----------------------------------------------------------------------------
module bge_lg #(
    parameter int COUNT_BITS    = bge_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = bge_pkg::FRACTION_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [COUNT_BITS-1:0]                      x,
    output logic                                       done,
    output logic [bge_pkg::LG_INT_W+FRACTION_BITS-1:0] result
);

    localparam int CW = $clog2(FRACTION_BITS);

    bge_pkg::lg_state_t          state_reg;
    bge_pkg::lg_state_t          state_next;
    logic [31:0]                 z_reg;
    logic [4:0]                  k_reg;
    logic [30:0]                 y_reg;
    logic [FRACTION_BITS-1:0]    frac_reg;
    logic [CW-1:0]               cnt_reg;
    logic [61:0]                 sq;
    logic [31:0]                 t;

    assign sq = 62'(y_reg) * 62'(y_reg);
    assign t  = sq[61:30];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bge_pkg::LG_IDLE: begin
                if (start) begin
                    state_next = (x == '0) ? bge_pkg::LG_DONE : bge_pkg::LG_NORM;
                end
            end
            bge_pkg::LG_NORM: begin
                if (z_reg[31]) begin
                    state_next = bge_pkg::LG_SQR;
                end
            end
            bge_pkg::LG_SQR: begin
                if (cnt_reg == CW'(FRACTION_BITS - 1)) begin
                    state_next = bge_pkg::LG_DONE;
                end
            end
            bge_pkg::LG_DONE: state_next = bge_pkg::LG_IDLE;
            default:          state_next = bge_pkg::LG_IDLE;
        endcase
    end

    always_comb begin
        done   = state_reg == bge_pkg::LG_DONE;
        result = {k_reg, frac_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bge_pkg::LG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bge_pkg::LG_IDLE: begin
                z_reg    <= 32'(x);
                k_reg    <= 5'd31;
                frac_reg <= '0;
                cnt_reg  <= '0;
                if (x == '0) begin
                    k_reg <= '0;
                end
            end
            bge_pkg::LG_NORM: begin
                if (z_reg[31]) begin
                    y_reg <= z_reg[31:1];
                end else begin
                    z_reg <= {z_reg[30:0], 1'b0};
                    k_reg <= k_reg - 1'b1;
                end
            end
            bge_pkg::LG_SQR: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (t[31]) begin
                    y_reg    <= t[31:1];
                    frac_reg <= {frac_reg[FRACTION_BITS-2:0], 1'b1};
                end else begin
                    y_reg    <= t[30:0];
                    frac_reg <= {frac_reg[FRACTION_BITS-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/bge_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bigram entropy back end
// Updates the three histograms and walks them to form the entropy results.
// ----------------------------------------------------------------------------
module bge_back #(
    parameter int COUNT_BITS    = bge_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = bge_pkg::FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  bge_pkg::q_entry_t     q_data,
    output logic                  q_pop,
    output bge_pkg::back_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bge_pkg::out_beat_t    m_data
);

    localparam int CB     = COUNT_BITS;
    localparam int LG_W   = bge_pkg::LG_INT_W + FRACTION_BITS;
    localparam int PROD_W = CB + LG_W;
    localparam int ACC_W  = CB + FRACTION_BITS + 6;
    localparam int DC_W   = $clog2(ACC_W);
    localparam int AW     = bge_pkg::PAIR_AW;
    localparam int UAW    = bge_pkg::UNI_AW;
    localparam logic [CB-1:0] LIMIT = {CB{1'b1}};

    bge_pkg::back_state_t state_reg;
    bge_pkg::back_state_t state_next;

    logic [AW-1:0]                init_addr_reg;
    logic                         sym_pend_reg;
    logic                         spc_pend_reg;
    logic                         fin_pend_reg;
    logic [bge_pkg::SYM_W-1:0]    cur_sym_reg;
    logic [bge_pkg::SYM_W-1:0]    prev_reg;
    logic                         prev_valid_reg;
    logic [CB-1:0]                seen_reg;
    logic                         ovf_reg;
    logic [1:0]                   tbl_reg;
    logic [AW-1:0]                idx_reg;
    logic [CB-1:0]                total_reg;
    logic [LG_W-1:0]              lt_reg;
    logic [CB-1:0]                c_reg;
    logic [LG_W-1:0]              diff_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [ACC_W-1:0]             acc_reg;
    logic [ACC_W-1:0]             divq_reg;
    logic [CB:0]                  rem_reg;
    logic [DC_W-1:0]              dcnt_reg;
    logic [bge_pkg::FIELD_W-1:0]  ent_uni_reg;
    logic [bge_pkg::FIELD_W-1:0]  ent_ovl_reg;
    logic [bge_pkg::FIELD_W-1:0]  ent_aln_reg;
    bge_pkg::out_beat_t           out_reg;
    logic                         m_valid_reg;

    logic [bge_pkg::SYM_W-1:0]    add_sym;
    logic [AW-1:0]                pair_key;
    logic [CB-1:0]                tot_sel;
    logic [CB-1:0]                c_sel;
    logic [AW-1:0]                last_idx;
    logic [CB:0]                  rem_sh;
    logic                         rem_ge;
    logic [ACC_W-1:0]             qsh;
    logic [bge_pkg::FIELD_W-1:0]  qsat;
    logic                         too_short;

    logic                         lg_start;
    logic [CB-1:0]                lg_x;
    logic                         lg_done;
    logic [LG_W-1:0]              lg_res;

    logic                         uni_we;
    logic                         ovl_we;
    logic                         aln_we;
    logic [UAW-1:0]               uni_waddr;
    logic [UAW-1:0]               uni_raddr;
    logic [AW-1:0]                pair_waddr;
    logic [AW-1:0]                pair_raddr;
    logic [CB-1:0]                uni_wdata;
    logic [CB-1:0]                ovl_wdata;
    logic [CB-1:0]                aln_wdata;
    logic [CB-1:0]                uni_rd;
    logic [CB-1:0]                ovl_rd;
    logic [CB-1:0]                aln_rd;

    bge_ram #(.WIDTH(CB), .DEPTH(bge_pkg::NSYM)) u_uni_ram (
        .aclk(aclk), .we(uni_we), .waddr(uni_waddr), .wdata(uni_wdata),
        .raddr(uni_raddr), .rdata(uni_rd)
    );

    bge_ram #(.WIDTH(CB), .DEPTH(bge_pkg::NPAIR)) u_ovl_ram (
        .aclk(aclk), .we(ovl_we), .waddr(pair_waddr), .wdata(ovl_wdata),
        .raddr(pair_raddr), .rdata(ovl_rd)
    );

    bge_ram #(.WIDTH(CB), .DEPTH(bge_pkg::NPAIR)) u_aln_ram (
        .aclk(aclk), .we(aln_we), .waddr(pair_waddr), .wdata(aln_wdata),
        .raddr(pair_raddr), .rdata(aln_rd)
    );

    bge_lg #(.COUNT_BITS(CB), .FRACTION_BITS(FRACTION_BITS)) u_lg (
        .aclk(aclk), .aresetn(aresetn), .start(lg_start), .x(lg_x),
        .done(lg_done), .result(lg_res)
    );

    always_comb begin
        add_sym  = sym_pend_reg ? cur_sym_reg : bge_pkg::SPACE_SYM;
        pair_key = AW'(prev_reg) * AW'(bge_pkg::NSYM) + AW'(add_sym);
        case (tbl_reg)
            bge_pkg::TBL_UNI: begin
                tot_sel  = seen_reg;
                c_sel    = uni_rd;
                last_idx = AW'(bge_pkg::NSYM - 1);
            end
            bge_pkg::TBL_OVL: begin
                tot_sel  = seen_reg - 1'b1;
                c_sel    = ovl_rd;
                last_idx = AW'(bge_pkg::NPAIR - 1);
            end
            default: begin
                tot_sel  = seen_reg >> 1;
                c_sel    = aln_rd;
                last_idx = AW'(bge_pkg::NPAIR - 1);
            end
        endcase
        rem_sh = {rem_reg[CB-1:0], divq_reg[ACC_W-1]};
        rem_ge = rem_sh >= {1'b0, total_reg};
        qsh    = (tbl_reg == bge_pkg::TBL_UNI) ? divq_reg : (divq_reg >> 1);
        qsat   = (64'(qsh) > 64'(bge_pkg::FIELD_MAX)) ? bge_pkg::FIELD_MAX
                                                       : bge_pkg::FIELD_W'(qsh);
        too_short = seen_reg < CB'(2);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bge_pkg::ST_INIT: begin
                if (init_addr_reg == AW'(bge_pkg::NPAIR - 1)) begin
                    state_next = bge_pkg::ST_IDLE;
                end
            end
            bge_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = bge_pkg::ST_DISPATCH;
                end
            end
            bge_pkg::ST_DISPATCH: begin
                if (sym_pend_reg || spc_pend_reg) begin
                    state_next = bge_pkg::ST_ADD_RD;
                end else if (fin_pend_reg) begin
                    state_next = bge_pkg::ST_LT_START;
                end else begin
                    state_next = bge_pkg::ST_IDLE;
                end
            end
            bge_pkg::ST_ADD_RD: begin
                state_next = (seen_reg == LIMIT) ? bge_pkg::ST_DISPATCH : bge_pkg::ST_ADD_WR;
            end
            bge_pkg::ST_ADD_WR:   state_next = bge_pkg::ST_DISPATCH;
            bge_pkg::ST_LT_START: state_next = bge_pkg::ST_LT_WAIT;
            bge_pkg::ST_LT_WAIT: begin
                if (lg_done) begin
                    state_next = bge_pkg::ST_RD;
                end
            end
            bge_pkg::ST_RD: state_next = bge_pkg::ST_DATA;
            bge_pkg::ST_DATA: begin
                state_next = (c_sel == '0) ? bge_pkg::ST_NEXT : bge_pkg::ST_LC_WAIT;
            end
            bge_pkg::ST_LC_WAIT: begin
                if (lg_done) begin
                    state_next = (lg_res < lt_reg) ? bge_pkg::ST_MUL : bge_pkg::ST_NEXT;
                end
            end
            bge_pkg::ST_MUL: state_next = bge_pkg::ST_ACC;
            bge_pkg::ST_ACC: state_next = bge_pkg::ST_NEXT;
            bge_pkg::ST_NEXT: begin
                state_next = (idx_reg == last_idx) ? bge_pkg::ST_DIV_START : bge_pkg::ST_RD;
            end
            bge_pkg::ST_DIV_START: begin
                state_next = (total_reg == '0) ? bge_pkg::ST_STORE : bge_pkg::ST_DIV;
            end
            bge_pkg::ST_DIV: begin
                if (dcnt_reg == DC_W'(ACC_W - 1)) begin
                    state_next = bge_pkg::ST_STORE;
                end
            end
            bge_pkg::ST_STORE: begin
                state_next = (tbl_reg == bge_pkg::TBL_ALN) ? bge_pkg::ST_RESULT
                                                           : bge_pkg::ST_LT_START;
            end
            bge_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = bge_pkg::ST_IDLE;
                end
            end
            default: state_next = bge_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop           = 1'b0;
        status.clearing = 1'b0;
        lg_start        = 1'b0;
        lg_x            = c_sel;
        uni_we          = 1'b0;
        ovl_we          = 1'b0;
        aln_we          = 1'b0;
        uni_waddr       = idx_reg[UAW-1:0];
        uni_raddr       = idx_reg[UAW-1:0];
        pair_waddr      = idx_reg;
        pair_raddr      = idx_reg;
        uni_wdata       = '0;
        ovl_wdata       = '0;
        aln_wdata       = '0;
        unique case (state_reg)
            bge_pkg::ST_INIT: begin
                status.clearing = 1'b1;
                uni_we     = init_addr_reg < AW'(bge_pkg::NSYM);
                ovl_we     = 1'b1;
                aln_we     = 1'b1;
                uni_waddr  = init_addr_reg[UAW-1:0];
                pair_waddr = init_addr_reg;
            end
            bge_pkg::ST_IDLE: q_pop = q_valid;
            bge_pkg::ST_ADD_RD: begin
                uni_raddr  = add_sym;
                pair_raddr = pair_key;
            end
            bge_pkg::ST_ADD_WR: begin
                uni_we     = 1'b1;
                ovl_we     = prev_valid_reg;
                aln_we     = prev_valid_reg && seen_reg[0];
                uni_waddr  = add_sym;
                pair_waddr = pair_key;
                uni_wdata  = uni_rd + 1'b1;
                ovl_wdata  = ovl_rd + 1'b1;
                aln_wdata  = aln_rd + 1'b1;
            end
            bge_pkg::ST_LT_START: begin
                lg_start = 1'b1;
                lg_x     = tot_sel;
            end
            bge_pkg::ST_RD: begin
                uni_we = tbl_reg == bge_pkg::TBL_UNI;
                ovl_we = tbl_reg == bge_pkg::TBL_OVL;
                aln_we = tbl_reg == bge_pkg::TBL_ALN;
            end
            bge_pkg::ST_DATA: lg_start = c_sel != '0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bge_pkg::ST_INIT;
            init_addr_reg  <= '0;
            sym_pend_reg   <= 1'b0;
            spc_pend_reg   <= 1'b0;
            fin_pend_reg   <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            seen_reg       <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                bge_pkg::ST_INIT: init_addr_reg <= init_addr_reg + 1'b1;
                bge_pkg::ST_IDLE: begin
                    if (q_valid) begin
                        sym_pend_reg <= q_data.sym_valid;
                        spc_pend_reg <= q_data.add_space;
                        fin_pend_reg <= q_data.finish;
                    end
                end
                bge_pkg::ST_ADD_RD: begin
                    if (seen_reg == LIMIT) begin
                        ovf_reg <= 1'b1;
                        if (sym_pend_reg) begin
                            sym_pend_reg <= 1'b0;
                        end else begin
                            spc_pend_reg <= 1'b0;
                        end
                    end
                end
                bge_pkg::ST_ADD_WR: begin
                    prev_reg       <= add_sym;
                    prev_valid_reg <= 1'b1;
                    seen_reg       <= seen_reg + 1'b1;
                    if (sym_pend_reg) begin
                        sym_pend_reg <= 1'b0;
                    end else begin
                        spc_pend_reg <= 1'b0;
                    end
                end
                bge_pkg::ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        fin_pend_reg   <= 1'b0;
                        prev_reg       <= '0;
                        prev_valid_reg <= 1'b0;
                        seen_reg       <= '0;
                        ovf_reg        <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bge_pkg::ST_IDLE: begin
                cur_sym_reg <= q_data.sym;
                tbl_reg     <= bge_pkg::TBL_UNI;
            end
            bge_pkg::ST_LT_START: begin
                total_reg <= tot_sel;
                acc_reg   <= '0;
                idx_reg   <= '0;
            end
            bge_pkg::ST_LT_WAIT: lt_reg <= lg_res;
            bge_pkg::ST_DATA:    c_reg  <= c_sel;
            bge_pkg::ST_LC_WAIT: diff_reg <= lt_reg - lg_res;
            bge_pkg::ST_MUL:     prod_reg <= PROD_W'(c_reg) * PROD_W'(diff_reg);
            bge_pkg::ST_ACC:     acc_reg  <= acc_reg + ACC_W'(prod_reg);
            bge_pkg::ST_NEXT:    idx_reg  <= idx_reg + 1'b1;
            bge_pkg::ST_DIV_START: begin
                divq_reg <= (total_reg == '0) ? '0 : acc_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            bge_pkg::ST_DIV: begin
                divq_reg <= {divq_reg[ACC_W-2:0], rem_ge};
                rem_reg  <= rem_ge ? (rem_sh - {1'b0, total_reg}) : rem_sh;
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            bge_pkg::ST_STORE: begin
                case (tbl_reg)
                    bge_pkg::TBL_UNI: ent_uni_reg <= qsat;
                    bge_pkg::TBL_OVL: ent_ovl_reg <= qsat;
                    default:          ent_aln_reg <= qsat;
                endcase
                tbl_reg <= tbl_reg + 1'b1;
            end
            bge_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_reg.unigram_entropy        <= too_short ? '0 : ent_uni_reg;
                    out_reg.overlap_bigram_entropy <= too_short ? '0 : ent_ovl_reg;
                    out_reg.paired_bigram_entropy  <= too_short ? '0 : ent_aln_reg;
                    out_reg.symbol_count <= (64'(seen_reg) > 64'(bge_pkg::FIELD_MAX))
                                            ? bge_pkg::FIELD_MAX
                                            : bge_pkg::FIELD_W'(seen_reg);
                    out_reg.too_short      <= too_short;
                    out_reg.count_overflow <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == bge_pkg::ST_IDLE)
        else $error("queue popped outside idle");

    a_no_count_past_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bge_pkg::ST_ADD_WR |-> seen_reg != LIMIT)
        else $error("histogram update at count limit");

    a_lg_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        lg_done |-> (state_reg == bge_pkg::ST_LT_WAIT || state_reg == bge_pkg::ST_LC_WAIT))
        else $error("logarithm finished while not awaited");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bge_pkg::ST_RESULT && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("result not presented");

endmodule

// File: hw/rtl/text_symbol_bigram_entropy_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text symbol bigram entropy unit
// Counts CP1251 letter symbols and pairs and reports their entropies.
// ----------------------------------------------------------------------------
// The front end takes one byte per cycle while no clearing pass runs and its
// four-beat queue has room. A byte that adds no symbol and does not end the
// text is taken and dropped in the front end. In the back end each symbol
// that a queued beat adds (a beat may add two) takes a read of the three
// histogram RAMs and a write of those it updates, so that loop sets the
// sustained rate. The byte marked as end of text starts a walk over all 2346
// histogram entries: a read of each entry, and for each non-zero count a
// logarithm (leading-one search from bit 31 and one squaring per fraction
// bit), then, where that logarithm is below the total's, a multiply and an
// accumulate; for each of the three tables one logarithm of its total and a
// division come on top. The walk clears each entry as it is read. After
// reset a pass that clears the histogram RAMs runs before the first byte is
// taken; configuration writes are taken at any time.
module text_symbol_bigram_entropy_unit #(
    parameter int COUNT_BITS    = bge_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = bge_pkg::FRACTION_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bge_pkg::in_beat_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bge_pkg::out_beat_t          m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bge_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic                  keep_spaces_reg;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    bge_pkg::q_entry_t     q_in;
    bge_pkg::q_entry_t     q_out;
    bge_pkg::back_status_t status;

    assign pready = 1'b1;
    assign prdata = (paddr == bge_pkg::REG_KEEP_SPACES) ? {31'd0, keep_spaces_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_spaces_reg <= 1'b1;
        end else if (psel && penable && pwrite && paddr == bge_pkg::REG_KEEP_SPACES) begin
            keep_spaces_reg <= pwdata[0];
        end
    end

    bge_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .keep_spaces(keep_spaces_reg), .status(status),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    bge_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .din(q_in), .pop(q_pop),
        .dout(q_out), .full(q_full), .empty(q_empty)
    );

    bge_back #(.COUNT_BITS(COUNT_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(!q_empty), .q_data(q_out),
        .q_pop(q_pop), .status(status), .m_valid(m_valid), .m_ready(m_ready),
        .m_data(m_data)
    );

endmodule

// File: sim/text_symbol_bigram_entropy_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bigram entropy unit testbench
// Streams CP1251 texts into the unit under changing idle patterns and both
// separator modes, predicts the entropy beat for each end of text, and
// checks every result beat field by field.
// ----------------------------------------------------------------------------
module text_symbol_bigram_entropy_unit_test;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES    = 20000;
    localparam int LG_FRAC        = bge_pkg::FRACTION_BITS_DEF;

    class entropy_scoreboard;
        longint unsigned    uni_cnt[bge_pkg::NSYM];
        longint unsigned    ovl_cnt[bge_pkg::NPAIR];
        longint unsigned    aln_cnt[bge_pkg::NPAIR];
        int unsigned        last_sym;
        bit                 last_ok;
        bit                 in_word;
        bit                 overflowed;
        bit                 keep_spaces;
        longint unsigned    sym_total;
        bge_pkg::out_beat_t expected_q[$];
        int                 errors;
        int                 results_checked;

        function new();
            clear_text();
            keep_spaces = 1;
            errors = 0;
            results_checked = 0;
        endfunction

        function void clear_text();
            foreach (uni_cnt[i]) uni_cnt[i] = 0;
            foreach (ovl_cnt[i]) ovl_cnt[i] = 0;
            foreach (aln_cnt[i]) aln_cnt[i] = 0;
            last_sym = 0;
            last_ok = 0;
            in_word = 0;
            overflowed = 0;
            sym_total = 0;
        endfunction

        function void count_symbol(int unsigned s);
            int unsigned k;
            if (sym_total >= (64'd1 << bge_pkg::COUNT_BITS_DEF) - 1) begin
                overflowed = 1;
                return;
            end
            uni_cnt[s]++;
            if (last_ok) begin
                k = last_sym * bge_pkg::NSYM + s;
                ovl_cnt[k]++;
                if (sym_total[0]) aln_cnt[k]++;
            end
            last_sym = s;
            last_ok = 1;
            sym_total++;
        endfunction

        function longint unsigned log2_q(longint unsigned x);
            int unsigned     k;
            longint unsigned y;
            longint unsigned frac;
            k = 0;
            frac = 0;
            if (x == 0) return 0;
            while (k < 63 && (x >> (k + 1)) != 0) k++;
            y = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
            for (int i = 0; i < LG_FRAC; i++) begin
                y = (y * y) >> 30;
                frac = frac << 1;
                if (y >= (64'd1 << 31)) begin
                    frac = frac | 1;
                    y = y >> 1;
                end
            end
            return (longint'(k) << LG_FRAC) | frac;
        endfunction

        function logic [bge_pkg::FIELD_W-1:0] entropy(logic [1:0] tbl,
                                                      longint unsigned total, int halve);
            longint unsigned lt;
            longint unsigned acc;
            longint unsigned c;
            longint unsigned lc;
            longint unsigned r;
            int              n;
            acc = 0;
            if (total == 0) return 0;
            lt = log2_q(total);
            n = (tbl == bge_pkg::TBL_UNI) ? bge_pkg::NSYM : bge_pkg::NPAIR;
            for (int i = 0; i < n; i++) begin
                case (tbl)
                    bge_pkg::TBL_UNI: c = uni_cnt[i];
                    bge_pkg::TBL_OVL: c = ovl_cnt[i];
                    default:          c = aln_cnt[i];
                endcase
                if (c != 0) begin
                    lc = log2_q(c);
                    if (lc < lt) acc += c * (lt - lc);
                end
            end
            r = (acc / total) >> halve;
            return (r > bge_pkg::FIELD_MAX) ? bge_pkg::FIELD_MAX : r[bge_pkg::FIELD_W-1:0];
        endfunction

        function void note_input(bge_pkg::in_beat_t b);
            int unsigned        v;
            int unsigned        s;
            longint unsigned    n;
            bge_pkg::out_beat_t e;
            v = b.text_byte;
            if (v >= 8'hC0 && v <= 8'hDF) v += 8'h20;
            if (v >= 8'hE0 || v == 8'hB8) begin
                if (v == 8'hB8) s = 6;
                else if (v - 8'hE0 <= 5) s = v - 8'hE0;
                else s = v - 8'hE0 + 1;
                count_symbol(s);
                in_word = 1;
            end else begin
                if (in_word && keep_spaces) count_symbol(bge_pkg::SPACE_SYM);
                in_word = 0;
            end
            if (!b.end_of_text) return;
            if (in_word && keep_spaces) count_symbol(bge_pkg::SPACE_SYM);
            n = sym_total;
            e = '0;
            if (n < 2) begin
                e.too_short = 1;
            end else begin
                e.unigram_entropy        = entropy(bge_pkg::TBL_UNI, n, 0);
                e.overlap_bigram_entropy = entropy(bge_pkg::TBL_OVL, n - 1, 1);
                e.paired_bigram_entropy  = entropy(bge_pkg::TBL_ALN, n / 2, 1);
            end
            e.symbol_count = (n > bge_pkg::FIELD_MAX) ? bge_pkg::FIELD_MAX
                                                      : n[bge_pkg::FIELD_W-1:0];
            e.count_overflow = overflowed;
            expected_q.push_back(e);
            clear_text();
        endfunction

        function void compare_field(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $error("%s mismatch: expected %0d, actual %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(bge_pkg::out_beat_t got);
            bge_pkg::out_beat_t e;
            if (expected_q.size() == 0) begin
                $error("result beat with no expected result pending");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            results_checked++;
            compare_field("unigram_entropy", e.unigram_entropy, got.unigram_entropy);
            compare_field("overlap_bigram_entropy", e.overlap_bigram_entropy,
                          got.overlap_bigram_entropy);
            compare_field("paired_bigram_entropy", e.paired_bigram_entropy,
                          got.paired_bigram_entropy);
            compare_field("symbol_count", e.symbol_count, got.symbol_count);
            compare_field("too_short", e.too_short, got.too_short);
            compare_field("count_overflow", e.count_overflow, got.count_overflow);
        endfunction
    endclass

    logic                        aclk = 0;
    logic                        aresetn = 0;
    logic                        s_valid = 0;
    logic                        s_ready;
    bge_pkg::in_beat_t           s_data = '0;
    logic                        m_valid;
    logic                        m_ready = 0;
    bge_pkg::out_beat_t          m_data;
    logic                        psel = 0;
    logic                        penable = 0;
    logic                        pwrite = 0;
    logic [bge_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    entropy_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_requests = 0;
    int  bytes_sent = 0;
    int  texts_sent = 0;
    int  quiet_cycles = 0;

    text_symbol_bigram_entropy_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : receiver
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (hold_requests != holds_done && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                holds_done = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_beat(logic [7:0] value, logic last);
        bge_pkg::in_beat_t b;
        b.text_byte = value;
        b.end_of_text = last;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b);
        bytes_sent++;
        if (last) texts_sent++;
    endtask

    task automatic write_keep_spaces(logic value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= bge_pkg::REG_KEEP_SPACES;
        pwdata <= {31'($urandom_range(32'h7FFF_FFFF)), value};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.keep_spaces = value;
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [7:0] letter_byte();
        case ($urandom_range(9))
            0: return 8'hB8;
            1, 2, 3: return 8'(8'hC0 + $urandom_range(31));
            default: return 8'(8'hE0 + $urandom_range(31));
        endcase
    endfunction

    function automatic logic [7:0] separator_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(8'hBF)); while (v == 8'hB8);
        return v;
    endfunction

    task automatic send_text(int max_len);
        logic [7:0] text_q[$];
        int         len;
        len = $urandom_range(1, max_len);
        if ($urandom_range(99) < 15) begin
            repeat (len) text_q.push_back(8'($urandom_range(255)));
        end else begin
            while (text_q.size() < len) begin
                repeat ($urandom_range(1, 8)) text_q.push_back(letter_byte());
                repeat ($urandom_range(1, 3)) text_q.push_back(separator_byte());
            end
            if ($urandom_range(1)) void'(text_q.pop_back());
        end
        foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
    endtask

    initial begin : stimulus
        logic [7:0] first_text[] = '{8'hC0, 8'hDF, 8'hE0, 8'hE5, 8'hE6, 8'hFF, 8'hB8,
                                    8'h00, 8'hA8, 8'hBF, 8'h7F, 8'hE0};
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (first_text[i]) send_beat(first_text[i], i == first_text.size() - 1);
        send_beat(8'h20, 1);
        send_beat(8'hE0, 1);
        wait_drained();
        write_keep_spaces(0);
        send_beat(8'hE0, 1);
        send_beat(8'hFF, 0);
        send_beat(8'h20, 0);
        send_beat(8'h2E, 0);
        send_beat(8'hFE, 0);
        send_beat(8'h40, 1);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_keep_spaces(phase[0]);
            repeat (7) send_text(50);
            if (phase == 4) begin
                hold_requests++;
                repeat (4) send_text(50);
            end
            if (phase == 7) send_text(600);
            wait_drained();
        end

        repeat (200) @(posedge aclk);
        $display("Covered %0d text bytes in %0d texts, %0d results checked,",
                 bytes_sent, texts_sent, sb.results_checked);
        $display("with both separator modes and four idle and stall patterns.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/bge_pkg.sv
hw/rtl/bge_ram.sv
hw/rtl/bge_front.sv
hw/rtl/bge_fifo.sv
hw/rtl/bge_lg.sv
hw/rtl/bge_back.sv
hw/rtl/text_symbol_bigram_entropy_unit.sv
sim/text_symbol_bigram_entropy_unit_test.sv
